// ===== rtl/bcf_pkg.sv =====
// ----------------------------------------------------------------------------
// bcf_pkg
// shared types and codes for the band cholesky factor and solve block
// ----------------------------------------------------------------------------
package bcf_pkg;

    localparam int MAX_SIZE_DEF = 64;
    localparam int MAX_BAND_DEF = 8;

    // item kinds
    typedef enum logic [1:0] {
        FUNC_WR_BAND = 2'd0,
        FUNC_FACTOR  = 2'd1,
        FUNC_WR_RHS  = 2'd2,
        FUNC_SOLVE   = 2'd3
    } func_t;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_PIVOT = 2'd1;
    localparam logic [1:0] ERR_SAT   = 2'd2;

    // configuration register indexes
    localparam logic CFG_MATRIX_SIZE = 1'b0;
    localparam logic CFG_BAND_WIDTH  = 1'b1;

    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_SUB  = 2'd1,
        ALU_DIV  = 2'd2,
        ALU_SQRT = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic sat;
        logic div_zero;
    } alu_status_t;

endpackage

// ===== rtl/bcf_alu.sv =====
// ----------------------------------------------------------------------------
// bcf_alu
// shared q16.16 unit: multiply, subtract, restoring divide, square root
// ----------------------------------------------------------------------------
module bcf_alu
    import bcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  alu_op_t            op,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] result,
    output alu_status_t        status
);

    typedef enum logic [2:0] {
        A_IDLE,
        A_MULF,
        A_DIV,
        A_DIVF,
        A_SQRT
    } alu_state_t;

    alu_state_t         state_reg;
    logic               done_reg;
    logic               sat_reg;
    logic               dz_reg;
    logic signed [31:0] res_reg;
    logic signed [63:0] prod_reg;
    logic [47:0]        quo_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        den_reg;
    logic               neg_reg;
    logic [5:0]         cnt_reg;
    logic [47:0]        x_reg;
    logic [26:0]        srem_reg;
    logic [23:0]        root_reg;

    logic [32:0]        sat_w;
    logic [32:0]        rem_sh;
    logic [26:0]        srem_sh;
    logic [26:0]        trial;
    logic signed [63:0] mul_adj;
    logic signed [63:0] quo_s;
    logic [31:0]        mag_a;
    logic [31:0]        mag_b;

    function automatic logic [32:0] sat64(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sd2147483647)
        begin
            r = {1'b1, 32'h7fffffff};
        end
        else if (v < -64'sd2147483648)
        begin
            r = {1'b1, 32'h80000000};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    always_comb
    begin
        mag_a   = a[31] ? (~a + 32'd1) : a;
        mag_b   = b[31] ? (~b + 32'd1) : b;
        rem_sh  = {rem_reg, quo_reg[47]};
        srem_sh = {srem_reg[24:0], x_reg[47:46]};
        trial   = {1'b0, root_reg, 2'b01};
        mul_adj = prod_reg + (prod_reg[63] ? 64'sd65535 : 64'sd0);
        quo_s   = $signed({16'd0, quo_reg});
        sat_w   = sat64(64'(a) - 64'(b));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            sat_reg   <= 1'b0;
            dz_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE:
                begin
                    if (start)
                    begin
                        unique case (op)
                            ALU_MUL:
                            begin
                                prod_reg  <= 64'(a) * 64'(b);
                                state_reg <= A_MULF;
                            end
                            ALU_SUB:
                            begin
                                res_reg  <= sat_w[31:0];
                                sat_reg  <= sat_w[32];
                                dz_reg   <= 1'b0;
                                done_reg <= 1'b1;
                            end
                            ALU_DIV:
                            begin
                                if (b == 32'sd0)
                                begin
                                    res_reg  <= 32'sd0;
                                    sat_reg  <= 1'b0;
                                    dz_reg   <= 1'b1;
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    quo_reg   <= {mag_a, 16'd0};
                                    rem_reg   <= 32'd0;
                                    den_reg   <= mag_b;
                                    neg_reg   <= a[31] ^ b[31];
                                    cnt_reg   <= 6'd47;
                                    state_reg <= A_DIV;
                                end
                            end
                            ALU_SQRT:
                            begin
                                x_reg     <= {a, 16'd0};
                                srem_reg  <= 27'd0;
                                root_reg  <= 24'd0;
                                cnt_reg   <= 6'd23;
                                state_reg <= A_SQRT;
                            end
                            default:
                            begin
                                state_reg <= A_IDLE;
                            end
                        endcase
                    end
                end
                A_MULF:
                begin
                    {sat_reg, res_reg} <= sat64(mul_adj >>> 16);
                    dz_reg    <= 1'b0;
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                A_DIV:
                begin
                    if (rem_sh >= {1'b0, den_reg})
                    begin
                        rem_reg <= 32'(rem_sh - {1'b0, den_reg});
                        quo_reg <= {quo_reg[46:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[31:0];
                        quo_reg <= {quo_reg[46:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= A_DIVF;
                    end
                end
                A_DIVF:
                begin
                    {sat_reg, res_reg} <= sat64(neg_reg ? -quo_s : quo_s);
                    dz_reg    <= 1'b0;
                    done_reg  <= 1'b1;
                    state_reg <= A_IDLE;
                end
                A_SQRT:
                begin
                    x_reg   <= {x_reg[45:0], 2'b00};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (srem_sh >= trial)
                    begin
                        srem_reg <= srem_sh - trial;
                        root_reg <= {root_reg[22:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg <= srem_sh;
                        root_reg <= {root_reg[22:0], 1'b0};
                    end
                    if (cnt_reg == 6'd0)
                    begin
                        res_reg   <= {8'd0, root_reg[22:0], (srem_sh >= trial)};
                        sat_reg   <= 1'b0;
                        dz_reg    <= 1'b0;
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign result          = res_reg;
    assign status.busy     = (state_reg != A_IDLE);
    assign status.done     = done_reg;
    assign status.sat      = sat_reg;
    assign status.div_zero = dz_reg;

endmodule

// ===== rtl/band_cholesky_factor_solve_top.sv =====
// ----------------------------------------------------------------------------
// band_cholesky_factor_solve_top
// band cholesky factor and forward/backward solve, q16.16, saturating
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one command per transfer: tuser holds the kind, tdata the
//   column, offset and value. band and rhs writes leave the block idle.
//   a factor command walks the columns with one shared unit, stopping at a
//   pivot that is not positive: per column a square root, one divide per
//   stored superdiagonal and bw*(bw+1)/2 multiply and subtract updates.
//   a solve command runs forward then backward substitution, per row a
//   multiply and subtract per band term plus a divide, then sends n results
//   on m_axis, each read from the rhs store after the one before is taken;
//   tlast marks the final element and each result carries the error status.
//   s_axis_tready is low for the whole run of a factor or solve command.
//   the shared unit and the single read port of each store serialize these steps.
//   a stalled receiver holds the result in the output register until taken.
//   reset clears error status and sets matrix_size 64 and band_width 8; the
//   band and rhs stores hold nothing valid until written. configuration
//   writes take effect at once; the user must make them while idle, unchecked.
// ----------------------------------------------------------------------------
module band_cholesky_factor_solve_top
    import bcf_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF,
    parameter int MAX_BAND = MAX_BAND_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // column[5:0], offset[9:6], value[41:10]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // index[5:0], solution[37:6], error[39:38]
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int CW     = $clog2(MAX_SIZE + 1);
    localparam int IW     = $clog2(MAX_SIZE);
    localparam int DW     = $clog2(MAX_BAND + 1);
    localparam int DW1    = $clog2(MAX_BAND + 2);
    localparam int BDEPTH = MAX_SIZE * (MAX_BAND + 1);
    localparam int AW     = $clog2(BDEPTH);
    localparam int LW     = ((CW > DW1) ? CW : DW1) + 1;

    typedef enum logic [4:0] {
        IDLE,
        F_K_TEST,
        F_PIV_RD,
        F_PIV_CHK,
        F_SQRT_W,
        F_SCL_TEST,
        F_SCL_RD,
        F_SCL_DIV,
        F_SCL_W,
        F_UPD_TEST,
        F_UPD_RDA,
        F_UPD_RDB,
        F_UPD_RDC,
        F_UPD_MW,
        F_UPD_SW,
        S_ROW_RD,
        S_ACC,
        S_DTEST,
        S_MUL,
        S_MW,
        S_SW,
        S_DIV,
        S_DW,
        E_RD,
        E_LD,
        E_WAIT
    } state_t;

    state_t             state_reg;
    logic [6:0]         matrix_size_reg;
    logic [3:0]         band_width_reg;
    logic [1:0]         err_reg;
    logic [CW-1:0]      k_reg;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      i_reg;
    logic [DW1-1:0]     d_reg;
    logic               bwd_reg;
    logic signed [31:0] piv_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] opa_reg;
    logic               tvalid_reg;
    logic [5:0]         out_idx_reg;
    logic [31:0]        out_sol_reg;
    logic               out_last_reg;
    logic [1:0]         out_err_reg;

    logic [31:0]        band_mem [BDEPTH];
    logic [31:0]        rhs_mem  [MAX_SIZE];
    logic signed [31:0] band_q;
    logic signed [31:0] rhs_q;

    logic               band_re;
    logic [AW-1:0]      band_raddr;
    logic               band_we;
    logic [AW-1:0]      band_waddr;
    logic [31:0]        band_wdata;
    logic               rhs_re;
    logic [IW-1:0]      rhs_raddr;
    logic               rhs_we;
    logic [IW-1:0]      rhs_waddr;
    logic [31:0]        rhs_wdata;

    logic               alu_start;
    alu_op_t            alu_op;
    logic signed [31:0] alu_a;
    logic signed [31:0] alu_b;
    logic signed [31:0] alu_res;
    alu_status_t        alu_stat;

    logic [CW-1:0]      n_eff;
    logic [DW-1:0]      bw_eff;
    logic               in_xfer;
    func_t              in_func;
    logic [5:0]         in_col;
    logic [3:0]         in_off;
    logic [31:0]        in_val;
    logic [LW-1:0]      ipd;
    logic               scl_ok;
    logic               row_ok;
    logic               term_ok;
    logic [DW-1:0]      off_jk;
    logic [DW-1:0]      off_ik;
    logic [DW-1:0]      off_ji;

    function automatic logic [AW-1:0] baddr(input logic [CW-1:0] col,
                                            input logic [DW-1:0] d);
        return AW'(int'(d) * MAX_SIZE + int'(col));
    endfunction

    bcf_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .status (alu_stat)
    );

    always_comb
    begin
        int ms;
        int bw;
        ms = int'(matrix_size_reg);
        bw = int'(band_width_reg);
        if (ms < 1)
        begin
            ms = 1;
        end
        if (ms > MAX_SIZE)
        begin
            ms = MAX_SIZE;
        end
        if (bw > MAX_BAND)
        begin
            bw = MAX_BAND;
        end
        n_eff  = CW'(ms);
        bw_eff = DW'(bw);
    end

    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign in_func = func_t'(s_axis_tuser);
    assign in_col  = s_axis_tdata[5:0];
    assign in_off  = s_axis_tdata[9:6];
    assign in_val  = s_axis_tdata[41:10];

    assign off_jk  = DW'(j_reg - k_reg);
    assign off_ik  = DW'(i_reg - k_reg);
    assign off_ji  = DW'(j_reg - i_reg);
    assign ipd     = LW'(i_reg) + LW'(d_reg);
    assign scl_ok  = (LW'(j_reg) < LW'(n_eff)) &&
                     (LW'(j_reg) <= (LW'(k_reg) + LW'(bw_eff)));
    assign row_ok  = bwd_reg ? (ipd < LW'(n_eff)) : (LW'(d_reg) <= LW'(i_reg));
    assign term_ok = (LW'(d_reg) <= LW'(bw_eff)) && row_ok;

    // memory port and shared unit control
    always_comb
    begin
        band_re    = 1'b0;
        band_raddr = '0;
        band_we    = 1'b0;
        band_waddr = '0;
        band_wdata = alu_res;
        rhs_re     = 1'b0;
        rhs_raddr  = '0;
        rhs_we     = 1'b0;
        rhs_waddr  = IW'(i_reg);
        rhs_wdata  = alu_res;
        alu_start  = 1'b0;
        alu_op     = ALU_MUL;
        alu_a      = band_q;
        alu_b      = band_q;
        unique case (state_reg)
            IDLE:
            begin
                if (in_xfer && (in_func == FUNC_WR_BAND) && (int'(in_col) < MAX_SIZE) &&
                    (int'(in_off) <= MAX_BAND) && (in_off <= in_col[3:0] || in_col > 6'd15))
                begin
                    band_we    = 1'b1;
                    band_waddr = AW'(int'(in_off) * MAX_SIZE + int'(in_col));
                    band_wdata = in_val;
                end
                if (in_xfer && (in_func == FUNC_WR_RHS) && (int'(in_col) < MAX_SIZE))
                begin
                    rhs_we    = 1'b1;
                    rhs_waddr = IW'(in_col);
                    rhs_wdata = in_val;
                end
            end
            F_PIV_RD:
            begin
                band_re    = 1'b1;
                band_raddr = baddr(k_reg, '0);
            end
            F_PIV_CHK:
            begin
                if (band_q > 32'sd0)
                begin
                    alu_start = 1'b1;
                    alu_op    = ALU_SQRT;
                end
            end
            F_SQRT_W:
            begin
                if (alu_stat.done)
                begin
                    band_we    = 1'b1;
                    band_waddr = baddr(k_reg, '0);
                end
            end
            F_SCL_RD:
            begin
                band_re    = 1'b1;
                band_raddr = baddr(j_reg, off_jk);
            end
            F_SCL_DIV:
            begin
                alu_start = 1'b1;
                alu_op    = ALU_DIV;
                alu_b     = piv_reg;
            end
            F_SCL_W:
            begin
                if (alu_stat.done)
                begin
                    band_we    = 1'b1;
                    band_waddr = baddr(j_reg, off_jk);
                end
            end
            F_UPD_RDA:
            begin
                band_re    = 1'b1;
                band_raddr = baddr(i_reg, off_ik);
            end
            F_UPD_RDB:
            begin
                band_re    = 1'b1;
                band_raddr = baddr(j_reg, off_jk);
            end
            F_UPD_RDC:
            begin
                band_re    = 1'b1;
                band_raddr = baddr(j_reg, off_ji);
                alu_start  = 1'b1;
                alu_op     = ALU_MUL;
                alu_a      = opa_reg;
            end
            F_UPD_MW:
            begin
                if (alu_stat.done)
                begin
                    alu_start = 1'b1;
                    alu_op    = ALU_SUB;
                    alu_b     = alu_res;
                end
            end
            F_UPD_SW:
            begin
                if (alu_stat.done)
                begin
                    band_we    = 1'b1;
                    band_waddr = baddr(j_reg, off_ji);
                end
            end
            S_ROW_RD:
            begin
                rhs_re    = 1'b1;
                rhs_raddr = IW'(i_reg);
            end
            S_DTEST:
            begin
                band_re = 1'b1;
                if (term_ok)
                begin
                    rhs_re = 1'b1;
                    if (bwd_reg)
                    begin
                        band_raddr = baddr(CW'(ipd), DW'(d_reg));
                        rhs_raddr  = IW'(ipd);
                    end
                    else
                    begin
                        band_raddr = baddr(i_reg, DW'(d_reg));
                        rhs_raddr  = IW'(i_reg - CW'(d_reg));
                    end
                end
                else
                begin
                    band_raddr = baddr(i_reg, '0);
                end
            end
            S_MUL:
            begin
                alu_start = 1'b1;
                alu_op    = ALU_MUL;
                alu_b     = rhs_q;
            end
            S_MW:
            begin
                if (alu_stat.done)
                begin
                    alu_start = 1'b1;
                    alu_op    = ALU_SUB;
                    alu_a     = acc_reg;
                    alu_b     = alu_res;
                end
            end
            S_DIV:
            begin
                alu_start = 1'b1;
                alu_op    = ALU_DIV;
                alu_a     = acc_reg;
            end
            S_DW:
            begin
                rhs_we = alu_stat.done;
            end
            E_RD:
            begin
                rhs_re    = 1'b1;
                rhs_raddr = IW'(k_reg);
            end
            default:
            begin
                band_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (band_we)
        begin
            band_mem[band_waddr] <= band_wdata;
        end
        if (band_re)
        begin
            band_q <= band_mem[band_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rhs_we)
        begin
            rhs_mem[rhs_waddr] <= rhs_wdata;
        end
        if (rhs_re)
        begin
            rhs_q <= rhs_mem[rhs_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            matrix_size_reg <= 7'd64;
            band_width_reg  <= 4'd8;
            err_reg         <= ERR_OK;
            tvalid_reg      <= 1'b0;
            bwd_reg         <= 1'b0;
            k_reg           <= '0;
            j_reg           <= '0;
            i_reg           <= '0;
            d_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MATRIX_SIZE)
                begin
                    matrix_size_reg <= cfg_data;
                end
                else
                begin
                    band_width_reg <= cfg_data[3:0];
                end
            end
            // sticky error codes, pivot code wins over saturation
            if (alu_stat.done)
            begin
                if (alu_stat.div_zero)
                begin
                    err_reg <= ERR_PIVOT;
                end
                else if (alu_stat.sat && (err_reg == ERR_OK))
                begin
                    err_reg <= ERR_SAT;
                end
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (in_xfer && (in_func == FUNC_FACTOR))
                    begin
                        err_reg   <= ERR_OK;
                        k_reg     <= '0;
                        state_reg <= F_K_TEST;
                    end
                    else if (in_xfer && (in_func == FUNC_SOLVE))
                    begin
                        i_reg     <= '0;
                        bwd_reg   <= 1'b0;
                        state_reg <= S_ROW_RD;
                    end
                end
                F_K_TEST:
                begin
                    state_reg <= (k_reg < n_eff) ? F_PIV_RD : IDLE;
                end
                F_PIV_RD:
                begin
                    state_reg <= F_PIV_CHK;
                end
                F_PIV_CHK:
                begin
                    if (band_q > 32'sd0)
                    begin
                        state_reg <= F_SQRT_W;
                    end
                    else
                    begin
                        err_reg   <= ERR_PIVOT;
                        state_reg <= IDLE;
                    end
                end
                F_SQRT_W:
                begin
                    if (alu_stat.done)
                    begin
                        piv_reg   <= alu_res;
                        j_reg     <= k_reg + CW'(1);
                        state_reg <= F_SCL_TEST;
                    end
                end
                F_SCL_TEST:
                begin
                    if (scl_ok)
                    begin
                        state_reg <= F_SCL_RD;
                    end
                    else
                    begin
                        j_reg     <= k_reg + CW'(1);
                        state_reg <= F_UPD_TEST;
                    end
                end
                F_SCL_RD:
                begin
                    state_reg <= F_SCL_DIV;
                end
                F_SCL_DIV:
                begin
                    state_reg <= F_SCL_W;
                end
                F_SCL_W:
                begin
                    if (alu_stat.done)
                    begin
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= F_SCL_TEST;
                    end
                end
                F_UPD_TEST:
                begin
                    if (scl_ok)
                    begin
                        i_reg     <= k_reg + CW'(1);
                        state_reg <= F_UPD_RDA;
                    end
                    else
                    begin
                        k_reg     <= k_reg + CW'(1);
                        state_reg <= F_K_TEST;
                    end
                end
                F_UPD_RDA:
                begin
                    state_reg <= F_UPD_RDB;
                end
                F_UPD_RDB:
                begin
                    opa_reg   <= band_q;
                    state_reg <= F_UPD_RDC;
                end
                F_UPD_RDC:
                begin
                    state_reg <= F_UPD_MW;
                end
                F_UPD_MW:
                begin
                    if (alu_stat.done)
                    begin
                        state_reg <= F_UPD_SW;
                    end
                end
                F_UPD_SW:
                begin
                    if (alu_stat.done)
                    begin
                        if (i_reg == j_reg)
                        begin
                            j_reg     <= j_reg + CW'(1);
                            state_reg <= F_UPD_TEST;
                        end
                        else
                        begin
                            i_reg     <= i_reg + CW'(1);
                            state_reg <= F_UPD_RDA;
                        end
                    end
                end
                S_ROW_RD:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg   <= rhs_q;
                    d_reg     <= DW1'(1);
                    state_reg <= S_DTEST;
                end
                S_DTEST:
                begin
                    state_reg <= term_ok ? S_MUL : S_DIV;
                end
                S_MUL:
                begin
                    state_reg <= S_MW;
                end
                S_MW:
                begin
                    if (alu_stat.done)
                    begin
                        state_reg <= S_SW;
                    end
                end
                S_SW:
                begin
                    if (alu_stat.done)
                    begin
                        acc_reg   <= alu_res;
                        d_reg     <= d_reg + DW1'(1);
                        state_reg <= S_DTEST;
                    end
                end
                S_DIV:
                begin
                    state_reg <= S_DW;
                end
                S_DW:
                begin
                    if (alu_stat.done)
                    begin
                        if (!bwd_reg)
                        begin
                            if (i_reg == n_eff - CW'(1))
                            begin
                                bwd_reg <= 1'b1;
                            end
                            else
                            begin
                                i_reg <= i_reg + CW'(1);
                            end
                            state_reg <= S_ROW_RD;
                        end
                        else if (i_reg == '0)
                        begin
                            k_reg     <= '0;
                            state_reg <= E_RD;
                        end
                        else
                        begin
                            i_reg     <= i_reg - CW'(1);
                            state_reg <= S_ROW_RD;
                        end
                    end
                end
                E_RD:
                begin
                    state_reg <= E_LD;
                end
                E_LD:
                begin
                    out_idx_reg  <= 6'(k_reg);
                    out_sol_reg  <= rhs_q;
                    out_last_reg <= (k_reg == n_eff - CW'(1));
                    out_err_reg  <= err_reg;
                    tvalid_reg   <= 1'b1;
                    state_reg    <= E_WAIT;
                end
                E_WAIT:
                begin
                    if (m_axis_tready)
                    begin
                        tvalid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            state_reg <= IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + CW'(1);
                            state_reg <= E_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == IDLE);
    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = {out_err_reg, out_sol_reg, out_idx_reg};
    assign m_axis_tlast  = out_last_reg;

    // no result pending while commands are taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("result pending while idle");

    // shared unit is only started when free
    assert property (@(posedge clk) disable iff (!rst_n)
        alu_start |-> !alu_stat.busy)
        else $error("shared unit started while busy");

    // last flag only on the final element of the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (k_reg == n_eff - CW'(1)))
        else $error("last flag on wrong element");

    // error status never holds an undefined code
    assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != 2'd3)
        else $error("bad error code");

endmodule

// ===== dv/bcf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcf_checker
// watches the command, result and configuration ports of the band cholesky
// block, predicts every solution element in q16.16 and compares in order
// ----------------------------------------------------------------------------
module bcf_checker
    import bcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [5:0]         index;
        logic signed [31:0] solution;
        logic               last;
        logic [1:0]         error;
    } sol_t;

    sol_t               sol_queue[$];
    logic signed [31:0] band_mem[64*9];
    logic signed [31:0] rhs_mem[64];
    logic [1:0]         err_stat;
    logic [6:0]         size_reg;
    logic [3:0]         bw_reg;

    assign pending = sol_queue.size();

    function automatic void raise_err(logic [1:0] code);
        if (code == ERR_PIVOT)
            err_stat = ERR_PIVOT;
        else if (err_stat == ERR_OK)
            err_stat = code;
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647)
        begin
            raise_err(ERR_SAT);
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            raise_err(ERR_SAT);
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat32(p / 65536);
    endfunction

    function automatic logic signed [31:0] fx_sub(logic signed [31:0] a, logic signed [31:0] b);
        return sat32(longint'(a) - longint'(b));
    endfunction

    function automatic logic signed [31:0] fx_div(logic signed [31:0] a, logic signed [31:0] b);
        if (b == 0)
        begin
            raise_err(ERR_PIVOT);
            return 0;
        end
        return sat32((longint'(a) * 65536) / longint'(b));
    endfunction

    function automatic logic signed [31:0] fx_sqrt(logic [31:0] a);
        longint unsigned x;
        longint unsigned res;
        longint unsigned b;
        x = longint'(a) << 16;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return sat32(longint'(res));
    endfunction

    function automatic int eff_size();
        if (size_reg < 1)
            return 1;
        if (size_reg > 64)
            return 64;
        return size_reg;
    endfunction

    function automatic int eff_bw();
        return (bw_reg > 8) ? 8 : bw_reg;
    endfunction

    function automatic void factor_band();
        int n;
        int bw;
        logic signed [31:0] piv;
        n = eff_size();
        bw = eff_bw();
        err_stat = ERR_OK;
        for (int k = 0; k < n; k++)
        begin
            piv = band_mem[k];
            if (piv <= 0)
            begin
                raise_err(ERR_PIVOT);
                return;
            end
            piv = fx_sqrt(piv);
            band_mem[k] = piv;
            for (int j = k + 1; j < n && j <= k + bw; j++)
                band_mem[j + 64*(j-k)] = fx_div(band_mem[j + 64*(j-k)], piv);
            for (int j = k + 1; j < n && j <= k + bw; j++)
                for (int i = k + 1; i <= j; i++)
                    band_mem[j + 64*(j-i)] = fx_sub(band_mem[j + 64*(j-i)],
                        fx_mul(band_mem[i + 64*(i-k)], band_mem[j + 64*(j-k)]));
        end
    endfunction

    function automatic void solve_band();
        int n;
        int bw;
        logic signed [31:0] acc;
        sol_t s;
        n = eff_size();
        bw = eff_bw();
        for (int i = 0; i < n; i++)
        begin
            acc = rhs_mem[i];
            for (int d = 1; d <= bw && d <= i; d++)
                acc = fx_sub(acc, fx_mul(band_mem[i + 64*d], rhs_mem[i-d]));
            rhs_mem[i] = fx_div(acc, band_mem[i]);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            acc = rhs_mem[i];
            for (int j = i + 1; j <= i + bw && j < n; j++)
                acc = fx_sub(acc, fx_mul(band_mem[j + 64*(j-i)], rhs_mem[j]));
            rhs_mem[i] = fx_div(acc, band_mem[i]);
        end
        for (int k = 0; k < n; k++)
        begin
            s.index = k[5:0];
            s.solution = rhs_mem[k];
            s.last = (k + 1 == n);
            s.error = err_stat;
            sol_queue.push_back(s);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [5:0] col;
        logic [3:0] off;
        sol_t exp_s;
        if (!rst_n)
        begin
            err_stat = ERR_OK;
            size_reg = 7'd64;
            bw_reg = 4'd8;
            fail_count = 0;
            sol_queue.delete();
            for (int i = 0; i < 64*9; i++)
                band_mem[i] = 0;
            for (int i = 0; i < 64; i++)
                rhs_mem[i] = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MATRIX_SIZE)
                    size_reg = cfg_data;
                else
                    bw_reg = cfg_data[3:0];
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (sol_queue.size() == 0)
                begin
                    $error("unexpected result transfer index %0d", m_axis_tdata[5:0]);
                    fail_count++;
                end
                else
                begin
                    exp_s = sol_queue.pop_front();
                    if (m_axis_tdata[5:0] !== exp_s.index)
                    begin
                        $error("index expected %0d actual %0d", exp_s.index,
                            m_axis_tdata[5:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[37:6] !== exp_s.solution)
                    begin
                        $error("solution expected %h actual %h", exp_s.solution,
                            m_axis_tdata[37:6]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== exp_s.last)
                    begin
                        $error("last expected %0d actual %0d", exp_s.last, m_axis_tlast);
                        fail_count++;
                    end
                    if (m_axis_tdata[39:38] !== exp_s.error)
                    begin
                        $error("error expected %0d actual %0d", exp_s.error,
                            m_axis_tdata[39:38]);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                col = s_axis_tdata[5:0];
                off = s_axis_tdata[9:6];
                case (func_t'(s_axis_tuser))
                    FUNC_WR_BAND:
                        if (off <= 8 && off <= col)
                            band_mem[col + 64*off] = s_axis_tdata[41:10];
                    FUNC_FACTOR:
                        factor_band();
                    FUNC_WR_RHS:
                        rhs_mem[col] = s_axis_tdata[41:10];
                    default:
                        solve_band();
                endcase
            end
        end
    end

endmodule

// ===== dv/tb_band_cholesky_factor_solve_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_band_cholesky_factor_solve_top
// drives band, rhs, factor and solve commands at random sizes and bandwidths
// with bursty input, a stalling receiver and one long hold-off
// ----------------------------------------------------------------------------
module tb_band_cholesky_factor_solve_top;
    import bcf_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [6:0]  cfg_data = '0;
    int          fail_count;
    int          pending;
    int          cmd_count = 0;
    int          burst_left = 0;
    int          cur_n;
    int          cur_bw;

    always #10 clk = ~clk;

    band_cholesky_factor_solve_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bcf_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver: shifting stall modes plus one long hold-off
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        bit held;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        held = 0;
        forever
        begin
            @(posedge clk);
            @(negedge clk);
            if (!held && pending >= 32 && m_axis_tvalid)
            begin
                held = 1;
                hold_left = 800;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready = 1'b0;
            end
            else if (mode == 0)
                m_axis_tready = 1'b1;
            else if (mode == 1)
                m_axis_tready = $urandom_range(0, 1);
            else
                m_axis_tready = ($urandom_range(0, 4) == 0);
        end
    end

    // one command transfer, entered and left at a falling edge
    task automatic push_cmd(func_t f, int col, int off, logic [31:0] val);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tuser = f;
        s_axis_tdata = {6'd0, val, off[3:0], col[5:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        cmd_count++;
    endtask

    task automatic go_idle();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_config(logic [6:0] size_raw, logic [3:0] bw_raw);
        go_idle();
        cfg_we = 1'b1;
        cfg_index = CFG_MATRIX_SIZE;
        cfg_data = size_raw;
        @(negedge clk);
        cfg_index = CFG_BAND_WIDTH;
        cfg_data = {3'd0, bw_raw};
        @(negedge clk);
        cfg_we = 1'b0;
        cur_n = (size_raw < 1) ? 1 : (size_raw > 64) ? 64 : size_raw;
        cur_bw = (bw_raw > 8) ? 8 : bw_raw;
    endtask

    function automatic logic [31:0] small_val();
        return $urandom_range(0, 32'h20000) - 32'h10000;
    endfunction

    task automatic push_noise();
        int col;
        int off;
        col = $urandom_range(0, 63);
        off = (col < 15) ? $urandom_range(col + 1, 15) : $urandom_range(9, 15);
        push_cmd(FUNC_WR_BAND, col, off, $urandom);
    endtask

    task automatic run_problem(int size_sel);
        int wild;
        logic [31:0] v;
        logic [6:0] sraw;
        logic [3:0] braw;
        if (size_sel == 64)
            sraw = ($urandom_range(0, 1) == 0) ? 7'd64 : 7'd127;
        else if (size_sel == 0)
            sraw = 7'd0;
        else
            sraw = 7'(size_sel);
        if (size_sel == 64)
            braw = 4'd0;
        else if (size_sel > 8)
            braw = 4'($urandom_range(0, 1));
        else
            braw = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) :
                4'($urandom_range(0, 8));
        set_config(sraw, braw);
        wild = ($urandom_range(0, 9) == 0);
        for (int j = 0; j < cur_n; j++)
            for (int d = 0; d <= cur_bw && d <= j; d++)
            begin
                if (wild)
                    v = $urandom;
                else if (d == 0)
                    v = ($urandom_range(4, 80) << 16) | $urandom_range(0, 16'hffff);
                else
                    v = small_val();
                push_cmd(FUNC_WR_BAND, j, d, v);
                if ($urandom_range(0, 15) == 0)
                    push_noise();
            end
        if ($urandom_range(0, 9) != 0)
            push_cmd(FUNC_FACTOR, $urandom_range(0, 63), $urandom_range(0, 15), $urandom);
        for (int j = 0; j < cur_n; j++)
            push_cmd(FUNC_WR_RHS, j, $urandom_range(0, 15),
                ($urandom_range(0, 3) == 0) ? $urandom : small_val() << 4);
        push_cmd(FUNC_SOLVE, $urandom_range(0, 63), $urandom_range(0, 15), $urandom);
        if (size_sel == 64 || $urandom_range(0, 4) == 0)
            push_cmd(FUNC_SOLVE, $urandom_range(0, 63), $urandom_range(0, 15), $urandom);
    endtask

    initial
    begin
        int iter;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero pivot, then a solve that hits a zero divisor
        set_config(7'd1, 4'd0);
        push_cmd(FUNC_WR_BAND, 0, 0, 32'h0);
        push_cmd(FUNC_FACTOR, 0, 0, 32'h0);
        push_cmd(FUNC_WR_RHS, 0, 0, 32'h7fffffff);
        push_cmd(FUNC_SOLVE, 0, 0, 32'h0);
        // largest pivot and most negative rhs
        push_cmd(FUNC_WR_BAND, 0, 0, 32'h7fffffff);
        push_cmd(FUNC_FACTOR, 63, 15, 32'hffffffff);
        push_cmd(FUNC_WR_RHS, 0, 0, 32'h80000000);
        push_cmd(FUNC_SOLVE, 63, 15, 32'hffffffff);
        // writes outside the matrix: offset past column, offset past the band, column past the size
        push_cmd(FUNC_WR_BAND, 0, 1, 32'h12345678);
        push_cmd(FUNC_WR_BAND, 63, 15, 32'hffffffff);
        push_cmd(FUNC_WR_BAND, 63, 8, 32'h5a5a5a5a);
        push_cmd(FUNC_WR_RHS, 63, 0, 32'ha5a5a5a5);
        // pivot that turns negative after the update
        set_config(7'd2, 4'd1);
        push_cmd(FUNC_WR_BAND, 0, 0, 32'h00010000);
        push_cmd(FUNC_WR_BAND, 1, 0, 32'h00010000);
        push_cmd(FUNC_WR_BAND, 1, 1, 32'h80000000);
        push_cmd(FUNC_FACTOR, 0, 0, 32'h0);
        push_cmd(FUNC_WR_RHS, 0, 0, 32'h00010000);
        push_cmd(FUNC_WR_RHS, 1, 0, 32'hffff0000);
        push_cmd(FUNC_SOLVE, 0, 0, 32'h0);

        iter = 0;
        while (cmd_count < 210)
        begin
            if (iter == 0)
                run_problem(0);
            else if (iter == 2)
                run_problem(64);
            else if ($urandom_range(0, 4) == 0)
                run_problem($urandom_range(9, 16));
            else
                run_problem($urandom_range(1, 8));
            iter++;
        end

        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bcf_pkg.sv
rtl/bcf_alu.sv
rtl/band_cholesky_factor_solve_top.sv
dv/bcf_checker.sv
dv/tb_band_cholesky_factor_solve_top.sv
